/* hw/rtl/hybrid_newton_bisection_root_macros.svh */
// Assertion macros for the hybrid Newton and bisection root finder.
`ifndef HYBRID_NEWTON_BISECTION_ROOT_MACROS_SVH
`define HYBRID_NEWTON_BISECTION_ROOT_MACROS_SVH
`ifndef SYNTHESIS
`define HNBR_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hnbr assertion failed");
`define HNBR_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hnbr assertion failed");
`else
`define HNBR_ASSERT_IMP(name, ante, cons)
`define HNBR_ASSERT_NEXT(name, ante, cons)
`endif
`endif

/* hw/rtl/hnbr_pkg.sv */
// Types, constants and the polynomial micro-op table of the root finder.
`timescale 1ns / 1ps
package hnbr_pkg;

	localparam int XW = 32;
	localparam int ACC_W = 50;
	localparam int CST_W = 18;
	localparam int CNT_W = 7;
	localparam int UOP_IDX_W = 4;
	localparam int LGDIV_SHIFT = 7;

	localparam logic [UOP_IDX_W-1:0] LEG_LAST = 4'd14;
	localparam logic [UOP_IDX_W-1:0] QUAD_LAST = 4'd0;

	localparam logic FSEL_QUAD = 1'b0;
	localparam logic FSEL_LEG = 1'b1;

	localparam logic signed [CST_W-1:0] LG8 = 18'sd6435;
	localparam logic signed [CST_W-1:0] LG6 = 18'sd12012;
	localparam logic signed [CST_W-1:0] LG4 = 18'sd6930;
	localparam logic signed [CST_W-1:0] LG2 = 18'sd1260;
	localparam logic signed [CST_W-1:0] LG0 = 18'sd35;
	localparam logic signed [CST_W-1:0] LD7 = 18'sd51480;
	localparam logic signed [CST_W-1:0] LD5 = 18'sd72072;
	localparam logic signed [CST_W-1:0] LD3 = 18'sd27720;
	localparam logic signed [CST_W-1:0] LD1 = 18'sd2520;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_EV_MUL,
		ST_EV_WB,
		ST_EV_FIN,
		ST_TAN_SUB,
		ST_TAN_LMUL,
		ST_TAN_LWB,
		ST_TAN_RMUL,
		ST_TAN_RWB,
		ST_STEP_SEL,
		ST_DIV,
		ST_DIV_Q,
		ST_DIV_X,
		ST_X1_SET,
		ST_TOL_MUL,
		ST_TOL_CHK,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		PW_P, PW_P2, PW_P3, PW_P4, PW_P5, PW_P6, PW_P7, PW_P8
	} pw_t;

	typedef enum logic [3:0] {
		DST_P2, DST_P3, DST_P4, DST_P5, DST_P6, DST_P7, DST_P8, DST_ACCF, DST_ACCD
	} dst_t;

	typedef struct packed {
		logic use_const;
		pw_t a_pw;
		pw_t b_pw;
		logic signed [CST_W-1:0] cval;
		dst_t dst;
		logic acc_load;
	} uop_t;

	// Step zero alone serves the quadratic; all fifteen serve the Legendre polynomial.
	function automatic uop_t leg_uop(input logic [UOP_IDX_W-1:0] idx);
		uop_t u;
		u = '{use_const: 1'b0, a_pw: PW_P, b_pw: PW_P, cval: '0, dst: DST_P2, acc_load: 1'b0};
		case (idx)
			4'd0: u = '{1'b0, PW_P, PW_P, '0, DST_P2, 1'b0};
			4'd1: u = '{1'b0, PW_P2, PW_P, '0, DST_P3, 1'b0};
			4'd2: u = '{1'b0, PW_P2, PW_P2, '0, DST_P4, 1'b0};
			4'd3: u = '{1'b0, PW_P4, PW_P, '0, DST_P5, 1'b0};
			4'd4: u = '{1'b0, PW_P4, PW_P2, '0, DST_P6, 1'b0};
			4'd5: u = '{1'b0, PW_P6, PW_P, '0, DST_P7, 1'b0};
			4'd6: u = '{1'b0, PW_P4, PW_P4, '0, DST_P8, 1'b0};
			4'd7: u = '{1'b1, PW_P, PW_P8, LG8, DST_ACCF, 1'b1};
			4'd8: u = '{1'b1, PW_P, PW_P6, -LG6, DST_ACCF, 1'b0};
			4'd9: u = '{1'b1, PW_P, PW_P4, LG4, DST_ACCF, 1'b0};
			4'd10: u = '{1'b1, PW_P, PW_P2, -LG2, DST_ACCF, 1'b0};
			4'd11: u = '{1'b1, PW_P, PW_P7, LD7, DST_ACCD, 1'b1};
			4'd12: u = '{1'b1, PW_P, PW_P5, -LD5, DST_ACCD, 1'b0};
			4'd13: u = '{1'b1, PW_P, PW_P3, LD3, DST_ACCD, 1'b0};
			4'd14: u = '{1'b1, PW_P, PW_P, -LD1, DST_ACCD, 1'b0};
			default: u = '{1'b0, PW_P, PW_P, '0, DST_P2, 1'b0};
		endcase
		return u;
	endfunction

endpackage

/* hw/rtl/hybrid_newton_bisection_root.sv */
// Safeguarded Newton and bisection root finder on a shared multiplier.
// Usage: configure function_select (0 quadratic x^2-2x-2, 1 degree-8 Legendre polynomial)
// over the cfg channel while the block is idle; cfg_ready is always high.
// Send one word of left_bound, right_bound (Q8.24 at the default FRAC_BITS) and tolerance
// (Q0.32) with item_valid; it is taken when item_stall is low, which is only while idle.
// One result word (root_estimate, bisection_count, newton_count, finish_status) follows
// on result_valid and is held until result_stall is low. The next item may be taken
// while that result still waits, but a new result waits until the old one has gone.
// Each evaluation runs one multiply for the quadratic and fifteen for the Legendre
// polynomial, each in a multiply state and a write-back state. A Newton step then runs
// the one-bit-a-cycle divider; a bisection step does not. At most MAX_ITER iterations.
// A new item is taken only once the previous one has returned to idle.
// Reset clears the sequencer, the result valid and selects the quadratic.
`timescale 1ns / 1ps
`include "hybrid_newton_bisection_root_macros.svh"
module hybrid_newton_bisection_root import hnbr_pkg::*; #(
	parameter int MAX_ITER = 64,
	parameter int FRAC_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic function_select,
	input logic item_valid,
	output logic item_stall,
	input logic signed [XW-1:0] left_bound,
	input logic signed [XW-1:0] right_bound,
	input logic [XW-1:0] tolerance,
	output logic result_valid,
	input logic result_stall,
	output logic signed [XW-1:0] root_estimate,
	output logic [CNT_W-1:0] bisection_count,
	output logic [CNT_W-1:0] newton_count,
	output logic finish_status
);

	localparam int IT_W = $clog2(MAX_ITER + 1);
	localparam int NW = XW + FRAC_BITS;
	localparam int DCNT_W = $clog2(NW);
	localparam int PW = 2 * XW + 2;
	localparam logic signed [XW-1:0] SMAX = {1'b0, {(XW-1){1'b1}}};
	localparam logic signed [XW-1:0] SMIN = {1'b1, {(XW-1){1'b0}}};
	localparam logic [PW-1:0] FX_LIM = PW'(1) << (XW - 1);
	localparam logic [NW-1:0] Q_LIM = NW'(1) << (XW - 1);
	localparam logic signed [XW+1:0] TWO_ONE = (XW+2)'(64'd2 << FRAC_BITS);
	localparam logic signed [ACC_W-1:0] LG0_ONE = ACC_W'(64'(LG0) << FRAC_BITS);
	localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(NW - 1);
	localparam logic [IT_W-1:0] IT_LAST = IT_W'(MAX_ITER - 1);

	state_t state_q, state_d;
	logic fsel_q;
	logic first_q;
	logic done_q;
	logic [UOP_IDX_W-1:0] ev_idx_q;
	logic [IT_W-1:0] it_q;
	logic [CNT_W-1:0] nb_q, nn_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic result_valid_q;

	logic signed [XW-1:0] xl_q, xr_q, x0_q, x1_q, p_q;
	logic signed [XW-1:0] p2_q, p3_q, p4_q, p5_q, p6_q, p7_q, p8_q;
	logic signed [ACC_W-1:0] accf_q, accd_q;
	logic signed [XW-1:0] fv_q, dv_q, fl_q, tl_q, tr_q, lt_q, rt_q, q_q;
	logic [XW-1:0] tol_q, ad_q, ax_q, dmag_q, rem_q;
	logic [NW-1:0] dq_q;
	logic qneg_q;
	logic signed [PW-1:0] prod_q;
	logic signed [XW-1:0] root_q;
	logic [CNT_W-1:0] nb_out_q, nn_out_q;
	logic fin_q;

	uop_t cur_uop;
	logic signed [XW:0] mul_a, mul_b;
	logic signed [XW-1:0] opa, opb;
	logic signed [XW-1:0] fxm, fv_new, dv_new, mid, qsat;
	logic take_newton, same_sign, conv, accept, ev_last_hit, res_go;
	logic [XW:0] div_r;
	logic div_ge;
	logic [XW:0] d_x;

	function automatic logic signed [XW-1:0] sat33(input logic signed [XW:0] v);
		if (v[XW] != v[XW-1]) begin
			return v[XW] ? SMIN : SMAX;
		end
		return v[XW-1:0];
	endfunction

	function automatic logic signed [XW-1:0] sat34(input logic signed [XW+1:0] v);
		if (!(v[XW+1:XW-1] == 3'b000 || v[XW+1:XW-1] == 3'b111)) begin
			return v[XW+1] ? SMIN : SMAX;
		end
		return v[XW-1:0];
	endfunction

	// Divide by 128 toward zero, then saturate to the word width.
	function automatic logic signed [XW-1:0] div128_sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] s;
		s = (v + (v[ACC_W-1] ? ACC_W'(127) : ACC_W'(0))) >>> LGDIV_SHIFT;
		if (!(s[ACC_W-1:XW-1] == '0 || s[ACC_W-1:XW-1] == '1)) begin
			return s[ACC_W-1] ? SMIN : SMAX;
		end
		return s[XW-1:0];
	endfunction

	// Fixed point product: truncate toward zero, then saturate.
	function automatic logic signed [XW-1:0] fx_sat(input logic signed [PW-1:0] p);
		logic neg;
		logic [PW-1:0] mag, sh;
		neg = p[PW-1];
		mag = neg ? PW'(-p) : PW'(p);
		sh = mag >> FRAC_BITS;
		if (neg) begin
			return (sh > FX_LIM) ? SMIN : XW'(-sh[XW-1:0]);
		end
		return (sh >= FX_LIM) ? SMAX : sh[XW-1:0];
	endfunction

	function automatic logic signed [XW-1:0] pw_read(input pw_t s);
		case (s)
			PW_P: return p_q;
			PW_P2: return p2_q;
			PW_P3: return p3_q;
			PW_P4: return p4_q;
			PW_P5: return p5_q;
			PW_P6: return p6_q;
			PW_P7: return p7_q;
			PW_P8: return p8_q;
			default: return p_q;
		endcase
	endfunction

	assign cfg_ready = 1'b1;
	assign item_stall = (state_q != ST_IDLE);
	assign accept = item_valid && (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign root_estimate = root_q;
	assign bisection_count = nb_out_q;
	assign newton_count = nn_out_q;
	assign finish_status = fin_q;
	assign res_go = !result_valid_q || !result_stall;

	assign cur_uop = leg_uop(ev_idx_q);
	assign ev_last_hit = (ev_idx_q == ((fsel_q == FSEL_LEG) ? LEG_LAST : QUAD_LAST));
	assign fxm = fx_sat(prod_q);

	// Shared multiplier operands.
	always_comb begin
		opa = pw_read(cur_uop.a_pw);
		opb = pw_read(cur_uop.b_pw);
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_EV_MUL: begin
				mul_a = cur_uop.use_const
					? {{(XW+1-CST_W){cur_uop.cval[CST_W-1]}}, cur_uop.cval}
					: {opa[XW-1], opa};
				mul_b = {opb[XW-1], opb};
			end
			ST_TAN_LMUL: begin
				mul_a = {tl_q[XW-1], tl_q};
				mul_b = {dv_q[XW-1], dv_q};
			end
			ST_TAN_RMUL: begin
				mul_a = {tr_q[XW-1], tr_q};
				mul_b = {dv_q[XW-1], dv_q};
			end
			ST_TOL_MUL: begin
				mul_a = {1'b0, tol_q};
				mul_b = {1'b0, ax_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		if (fsel_q == FSEL_LEG) begin
			fv_new = div128_sat(accf_q);
			dv_new = div128_sat(accd_q);
		end else begin
			fv_new = sat34({{2{p2_q[XW-1]}}, p2_q} - ({{2{p_q[XW-1]}}, p_q} <<< 1) - TWO_ONE);
			dv_new = sat34(({{2{p_q[XW-1]}}, p_q} <<< 1) - TWO_ONE);
		end
	end

	logic signed [XW:0] mid_sum, mid_adj;
	assign mid_sum = {xl_q[XW-1], xl_q} + {xr_q[XW-1], xr_q};
	assign mid_adj = mid_sum + {{XW{1'b0}}, mid_sum[XW]};
	assign mid = XW'(mid_adj >>> 1);

	assign take_newton = (dv_q != '0) &&
		((!lt_q[XW-1] && lt_q != '0 && rt_q[XW-1]) ||
		(lt_q[XW-1] && !rt_q[XW-1] && rt_q != '0));
	assign same_sign = (!fl_q[XW-1] && fl_q != '0 && !fv_q[XW-1] && fv_q != '0) ||
		(fl_q[XW-1] && fv_q[XW-1]);
	assign conv = !ad_q[XW-1] && ({ad_q, {XW{1'b0}}} <= prod_q[2*XW-1:0]);

	assign div_r = {rem_q, dq_q[NW-1]};
	assign div_ge = (div_r >= {1'b0, dmag_q});

	always_comb begin
		if (qneg_q) begin
			qsat = (dq_q > Q_LIM) ? SMIN : XW'(-dq_q[XW-1:0]);
		end else begin
			qsat = (dq_q >= Q_LIM) ? SMAX : dq_q[XW-1:0];
		end
	end

	assign d_x = {x1_q[XW-1], x1_q} - {x0_q[XW-1], x0_q};

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (item_valid) begin
				state_d = ST_EV_MUL;
			end
			ST_EV_MUL: state_d = ST_EV_WB;
			ST_EV_WB: state_d = ev_last_hit ? ST_EV_FIN : ST_EV_MUL;
			ST_EV_FIN: state_d = first_q ? ST_TAN_SUB : ST_TOL_MUL;
			ST_TAN_SUB: state_d = ST_TAN_LMUL;
			ST_TAN_LMUL: state_d = ST_TAN_LWB;
			ST_TAN_LWB: state_d = ST_TAN_RMUL;
			ST_TAN_RMUL: state_d = ST_TAN_RWB;
			ST_TAN_RWB: state_d = ST_STEP_SEL;
			ST_STEP_SEL: state_d = take_newton ? ST_DIV : ST_X1_SET;
			ST_DIV: state_d = (div_cnt_q == DIV_LAST) ? ST_DIV_Q : ST_DIV;
			ST_DIV_Q: state_d = ST_DIV_X;
			ST_DIV_X: state_d = ST_X1_SET;
			ST_X1_SET: state_d = ST_EV_MUL;
			ST_TOL_MUL: state_d = ST_TOL_CHK;
			ST_TOL_CHK: state_d = (conv || it_q == IT_LAST) ? ST_FINISH : ST_TAN_SUB;
			ST_FINISH: state_d = res_go ? ST_IDLE : ST_FINISH;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsel_q <= FSEL_QUAD;
			first_q <= 1'b0;
			done_q <= 1'b0;
			ev_idx_q <= '0;
			it_q <= '0;
			nb_q <= '0;
			nn_q <= '0;
			div_cnt_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				fsel_q <= function_select;
			end
			if (accept) begin
				first_q <= 1'b1;
				done_q <= 1'b0;
				ev_idx_q <= '0;
				it_q <= '0;
				nb_q <= '0;
				nn_q <= '0;
			end
			if (state_q == ST_EV_WB && !ev_last_hit) begin
				ev_idx_q <= ev_idx_q + 1'b1;
			end
			if (state_q == ST_EV_FIN) begin
				first_q <= 1'b0;
			end
			if (state_q == ST_X1_SET) begin
				ev_idx_q <= '0;
			end
			if (state_q == ST_STEP_SEL) begin
				div_cnt_q <= '0;
				if (take_newton) begin
					nn_q <= nn_q + 1'b1;
				end else begin
					nb_q <= nb_q + 1'b1;
				end
			end
			if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (state_q == ST_TOL_CHK) begin
				it_q <= it_q + 1'b1;
				done_q <= conv;
			end
			if (state_q == ST_FINISH && res_go) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: if (accept) begin
				xl_q <= left_bound;
				xr_q <= right_bound;
				x0_q <= left_bound;
				x1_q <= left_bound;
				p_q <= left_bound;
				tol_q <= tolerance;
			end
			ST_EV_WB: begin
				case (cur_uop.dst)
					DST_P2: p2_q <= fxm;
					DST_P3: p3_q <= fxm;
					DST_P4: p4_q <= fxm;
					DST_P5: p5_q <= fxm;
					DST_P6: p6_q <= fxm;
					DST_P7: p7_q <= fxm;
					DST_P8: p8_q <= fxm;
					DST_ACCF: accf_q <= cur_uop.acc_load ? prod_q[ACC_W-1:0] + LG0_ONE
						: accf_q + prod_q[ACC_W-1:0];
					DST_ACCD: accd_q <= cur_uop.acc_load ? prod_q[ACC_W-1:0]
						: accd_q + prod_q[ACC_W-1:0];
					default: p2_q <= fxm;
				endcase
			end
			ST_EV_FIN: begin
				fv_q <= fv_new;
				dv_q <= dv_new;
				if (first_q) begin
					fl_q <= fv_new;
				end
			end
			ST_TAN_SUB: begin
				tl_q <= sat33({x0_q[XW-1], x0_q} - {xl_q[XW-1], xl_q});
				tr_q <= sat33({x0_q[XW-1], x0_q} - {xr_q[XW-1], xr_q});
			end
			ST_TAN_LWB: lt_q <= sat33({fxm[XW-1], fxm} - {fv_q[XW-1], fv_q});
			ST_TAN_RWB: rt_q <= sat33({fxm[XW-1], fxm} - {fv_q[XW-1], fv_q});
			ST_STEP_SEL: begin
				if (take_newton) begin
					dq_q <= {(fv_q[XW-1] ? XW'(-fv_q) : XW'(fv_q)), {FRAC_BITS{1'b0}}};
					dmag_q <= dv_q[XW-1] ? XW'(-dv_q) : XW'(dv_q);
					rem_q <= '0;
					qneg_q <= fv_q[XW-1] ^ dv_q[XW-1];
				end else begin
					x1_q <= mid;
				end
			end
			ST_DIV: begin
				rem_q <= div_ge ? XW'(div_r - {1'b0, dmag_q}) : div_r[XW-1:0];
				dq_q <= {dq_q[NW-2:0], div_ge};
			end
			ST_DIV_Q: q_q <= qsat;
			ST_DIV_X: x1_q <= sat33({x0_q[XW-1], x0_q} - {q_q[XW-1], q_q});
			ST_X1_SET: begin
				p_q <= x1_q;
				ad_q <= d_x[XW] ? XW'(-d_x) : d_x[XW-1:0];
				ax_q <= x1_q[XW-1] ? XW'(-x1_q) : XW'(x1_q);
			end
			ST_TOL_CHK: begin
				// The new iterate's function value is already in fv_q.
				if (same_sign) begin
					xl_q <= x1_q;
					fl_q <= fv_q;
				end else begin
					xr_q <= x1_q;
				end
				x0_q <= x1_q;
			end
			ST_FINISH: if (res_go) begin
				root_q <= x1_q;
				nb_out_q <= nb_q;
				nn_out_q <= nn_q;
				fin_q <= !done_q;
			end
			default: begin
			end
		endcase
	end

	`HNBR_ASSERT_IMP(a_count_sum, (state_q == ST_TAN_SUB), (nb_q + nn_q == CNT_W'(it_q)))
	`HNBR_ASSERT_IMP(a_div_nonzero, (state_q == ST_DIV), (dmag_q != '0))
	`HNBR_ASSERT_IMP(a_result_from_finish, $rose(result_valid_q), $past(state_q == ST_FINISH))
	`HNBR_ASSERT_NEXT(a_eval_point, (state_q == ST_X1_SET), (ev_idx_q == '0 && p_q == x1_q))

endmodule
